[rtl/core/amd_pkg.sv]
package amd_pkg;

    // Calibration length is 2^CAL_LOG2 samples (range 0..10).
    localparam int CAL_LOG2 = 6;

    localparam int AXIS_W  = 16;
    localparam int SUM_W   = 27;
    localparam int COUNT_W = 11;
    localparam int MAG_W   = 32;
    localparam int SQ_W    = 31;
    localparam int THR_W   = 15;
    localparam int THR_SQ_W = 2 * THR_W;

    localparam logic [COUNT_W-1:0] CAL_TARGET = COUNT_W'(1 << CAL_LOG2);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 1'b1;

    localparam int THRESHOLD_RESET = 1000;
    localparam logic [THR_SQ_W-1:0] THR_SQ_RESET =
        THR_SQ_W'(THRESHOLD_RESET * THRESHOLD_RESET);
    localparam logic [COUNT_W-1:0] WINDOW_RESET = COUNT_W'(16);

    // Largest possible squared magnitude: three axes at full scale
    localparam logic [MAG_W-1:0] MAG_MAX = 32'd3221225472;

    typedef enum logic {
        CMD_CAL    = 1'b0,
        CMD_DETECT = 1'b1
    } t_cmd;

    typedef enum logic {
        KIND_CAL    = 1'b0,
        KIND_WINDOW = 1'b1
    } t_kind;

    // Offset-corrected sample and its squared magnitude
    typedef struct packed {
        logic signed [AXIS_W-1:0] cx;
        logic signed [AXIS_W-1:0] cy;
        logic signed [AXIS_W-1:0] cz;
        logic        [MAG_W-1:0]  mag;
    } t_det;

endpackage

[rtl/core/amd_correct.sv]
module amd_correct (
    input  logic signed [amd_pkg::AXIS_W-1:0] i_ax,
    input  logic signed [amd_pkg::AXIS_W-1:0] i_ay,
    input  logic signed [amd_pkg::AXIS_W-1:0] i_az,
    input  logic signed [amd_pkg::AXIS_W-1:0] i_off_x,
    input  logic signed [amd_pkg::AXIS_W-1:0] i_off_y,
    input  logic signed [amd_pkg::AXIS_W-1:0] i_off_z,
    output amd_pkg::t_det                     o_det
);
    import amd_pkg::*;

    function automatic logic signed [AXIS_W-1:0] sub_sat(
        input logic signed [AXIS_W-1:0] a,
        input logic signed [AXIS_W-1:0] b
    );
        logic signed [AXIS_W:0] d;
        d = {a[AXIS_W-1], a} - {b[AXIS_W-1], b};
        // Clip to signed 16 bits when the two top bits disagree
        if (d[AXIS_W] != d[AXIS_W-1]) begin
            sub_sat = d[AXIS_W] ? {1'b1, {(AXIS_W-1){1'b0}}} : {1'b0, {(AXIS_W-1){1'b1}}};
        end else begin
            sub_sat = d[AXIS_W-1:0];
        end
    endfunction

    function automatic logic [SQ_W-1:0] square(input logic signed [AXIS_W-1:0] v);
        logic signed [2*AXIS_W-1:0] p;
        p = v * v;
        square = p[SQ_W-1:0];
    endfunction

    logic signed [AXIS_W-1:0] w_cx, w_cy, w_cz;

    assign w_cx = sub_sat(i_ax, i_off_x);
    assign w_cy = sub_sat(i_ay, i_off_y);
    assign w_cz = sub_sat(i_az, i_off_z);

    assign o_det.cx  = w_cx;
    assign o_det.cy  = w_cy;
    assign o_det.cz  = w_cz;
    assign o_det.mag = MAG_W'(square(w_cx)) + MAG_W'(square(w_cy)) + MAG_W'(square(w_cz));

endmodule

[rtl/core/accel_motion_detector.sv]
// An accepted item is held in the input register, then its result in the result register
// (the processing stage between them is combinational).
// Throughput: one item per cycle; a stalled result holds back only items that produce one.
// Reset (synchronous, active low): clears offsets, sums, counters, window peak and valids,
// and loads threshold 1000 and window length 16. No clearing pass is needed.
module accel_motion_detector (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [amd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [amd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // sample channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic                               i_command,
    input  logic signed [amd_pkg::AXIS_W-1:0]  i_accel_x,
    input  logic signed [amd_pkg::AXIS_W-1:0]  i_accel_y,
    input  logic signed [amd_pkg::AXIS_W-1:0]  i_accel_z,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_result_kind,
    output logic                               o_active,
    output logic signed [amd_pkg::AXIS_W-1:0]  o_out_x,
    output logic signed [amd_pkg::AXIS_W-1:0]  o_out_y,
    output logic signed [amd_pkg::AXIS_W-1:0]  o_out_z,
    output logic [amd_pkg::MAG_W-1:0]          o_peak_mag_sq
);
    import amd_pkg::*;

    // Configuration: keep threshold already squared, computed at write time
    logic [THR_SQ_W-1:0]          r_thr_sq;
    logic [COUNT_W-1:0]           r_win_len;

    // Input register
    logic                         r_in_valid;
    t_cmd                         r_cmd;
    logic signed [AXIS_W-1:0]     r_ax, r_ay, r_az;

    // Block state
    logic signed [AXIS_W-1:0]     r_off_x, r_off_y, r_off_z;
    logic signed [SUM_W-1:0]      r_sum_x, r_sum_y, r_sum_z;
    logic [COUNT_W-1:0]           r_cal_count;
    logic [COUNT_W-1:0]           r_win_count;
    logic signed [AXIS_W-1:0]     r_best_x, r_best_y, r_best_z;
    logic [MAG_W-1:0]             r_best_mag;

    // Result register
    logic                         r_out_valid;
    t_kind                        r_out_kind;
    logic                         r_out_active;
    logic signed [AXIS_W-1:0]     r_out_x, r_out_y, r_out_z;
    logic [MAG_W-1:0]             r_out_mag;

    // Processing stage
    t_det                         w_det;
    logic                         w_is_det;
    logic [COUNT_W-1:0]           n_cal_count, n_win_count, w_len;
    logic                         w_cal_done, w_win_done, w_res, w_fire;
    logic signed [SUM_W-1:0]      n_sum_x, n_sum_y, n_sum_z;
    logic signed [SUM_W-1:0]      w_shr_x, w_shr_y, w_shr_z;
    logic                         w_better, w_active;
    logic signed [AXIS_W-1:0]     w_pk_x, w_pk_y, w_pk_z;
    logic [MAG_W-1:0]             w_pk_mag;

    amd_correct u_correct (
        .i_ax    (r_ax),
        .i_ay    (r_ay),
        .i_az    (r_az),
        .i_off_x (r_off_x),
        .i_off_y (r_off_y),
        .i_off_z (r_off_z),
        .o_det   (w_det)
    );

    assign w_is_det    = (r_cmd == CMD_DETECT);

    // Window and calibration progress; a zero window length acts as one
    assign n_cal_count = r_cal_count + COUNT_W'(1);
    assign n_win_count = r_win_count + COUNT_W'(1);
    assign w_len       = (r_win_len == '0) ? COUNT_W'(1) : r_win_len;
    assign w_cal_done  = (n_cal_count >= CAL_TARGET);
    assign w_win_done  = (n_win_count >= w_len);
    assign w_res       = w_is_det ? w_win_done : w_cal_done;

    // Advance the held item unless it makes a result and the result slot stays full
    assign w_fire      = r_in_valid && (!w_res || !r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_fire;

    // Calibration: raw sums, floor mean by arithmetic shift
    assign n_sum_x = r_sum_x + SUM_W'(r_ax);
    assign n_sum_y = r_sum_y + SUM_W'(r_ay);
    assign n_sum_z = r_sum_z + SUM_W'(r_az);
    assign w_shr_x = n_sum_x >>> CAL_LOG2;
    assign w_shr_y = n_sum_y >>> CAL_LOG2;
    assign w_shr_z = n_sum_z >>> CAL_LOG2;

    // Peak tracking: only a strictly larger magnitude replaces the held one
    assign w_better = (w_det.mag > r_best_mag);
    assign w_pk_x   = w_better ? w_det.cx  : r_best_x;
    assign w_pk_y   = w_better ? w_det.cy  : r_best_y;
    assign w_pk_z   = w_better ? w_det.cz  : r_best_z;
    assign w_pk_mag = w_better ? w_det.mag : r_best_mag;
    // The new peak is the max of the two, so compare both against the limit in parallel
    assign w_active = (r_best_mag > MAG_W'(r_thr_sq)) || (w_det.mag > MAG_W'(r_thr_sq));

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr_sq  <= THR_SQ_RESET;
            r_win_len <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_THRESHOLD: r_thr_sq  <= {{THR_W{1'b0}}, i_cfg_data[THR_W-1:0]}
                                          * {{THR_W{1'b0}}, i_cfg_data[THR_W-1:0]};
                CFG_WINDOW:    r_win_len <= i_cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register: hold the item until the processing stage takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_cmd <= t_cmd'(i_command);
            r_ax  <= i_accel_x;
            r_ay  <= i_accel_y;
            r_az  <= i_accel_z;
        end
    end

    // Calibration and window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x     <= '0;
            r_off_y     <= '0;
            r_off_z     <= '0;
            r_sum_x     <= '0;
            r_sum_y     <= '0;
            r_sum_z     <= '0;
            r_cal_count <= '0;
            r_win_count <= '0;
            r_best_x    <= '0;
            r_best_y    <= '0;
            r_best_z    <= '0;
            r_best_mag  <= '0;
        end else if (w_fire) begin
            if (w_is_det) begin
                if (w_win_done) begin
                    // Window closes: start the next one empty
                    r_best_x    <= '0;
                    r_best_y    <= '0;
                    r_best_z    <= '0;
                    r_best_mag  <= '0;
                    r_win_count <= '0;
                end else begin
                    r_best_x    <= w_pk_x;
                    r_best_y    <= w_pk_y;
                    r_best_z    <= w_pk_z;
                    r_best_mag  <= w_pk_mag;
                    r_win_count <= n_win_count;
                end
            end else begin
                if (w_cal_done) begin
                    // Latch the new offsets and drop the sums
                    r_off_x     <= w_shr_x[AXIS_W-1:0];
                    r_off_y     <= w_shr_y[AXIS_W-1:0];
                    r_off_z     <= w_shr_z[AXIS_W-1:0];
                    r_sum_x     <= '0;
                    r_sum_y     <= '0;
                    r_sum_z     <= '0;
                    r_cal_count <= '0;
                end else begin
                    r_sum_x     <= n_sum_x;
                    r_sum_y     <= n_sum_y;
                    r_sum_z     <= n_sum_z;
                    r_cal_count <= n_cal_count;
                end
            end
        end
    end

    // Result register: load on a result, drop once the item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_res) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res) begin
            if (w_is_det) begin
                r_out_kind   <= KIND_WINDOW;
                r_out_active <= w_active;
                r_out_x      <= w_pk_x;
                r_out_y      <= w_pk_y;
                r_out_z      <= w_pk_z;
                r_out_mag    <= w_pk_mag;
            end else begin
                r_out_kind   <= KIND_CAL;
                r_out_active <= 1'b0;
                r_out_x      <= w_shr_x[AXIS_W-1:0];
                r_out_y      <= w_shr_y[AXIS_W-1:0];
                r_out_z      <= w_shr_z[AXIS_W-1:0];
                r_out_mag    <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_active      = r_out_active;
    assign o_out_x       = r_out_x;
    assign o_out_y       = r_out_y;
    assign o_out_z       = r_out_z;
    assign o_peak_mag_sq = r_out_mag;

endmodule

[rtl/core/amd_checker.sv]
module amd_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_out_valid,
    input logic                              i_out_ready,
    input logic                              o_result_kind,
    input logic                              o_active,
    input logic signed [amd_pkg::AXIS_W-1:0] o_out_x,
    input logic [amd_pkg::MAG_W-1:0]         o_peak_mag_sq
);
    import amd_pkg::*;

    // A result held under backpressure stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_peak_mag_sq)
            && $stable(o_out_x) && $stable(o_result_kind) && $stable(o_active))
        else $error("result changed while stalled");

    // Calibration results carry no verdict and no magnitude
    a_cal_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_result_kind == KIND_CAL) |-> !o_active && (o_peak_mag_sq == '0))
        else $error("calibration result with verdict fields set");

    // An active window has a nonzero peak
    a_active_peak: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_active |-> (o_peak_mag_sq != '0))
        else $error("active verdict with zero peak");

    // Peak never exceeds three full-scale squares
    a_peak_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_peak_mag_sq <= MAG_MAX))
        else $error("peak magnitude out of range");

    // Reset empties the result slot
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind accel_motion_detector amd_checker u_amd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_result_kind (o_result_kind),
    .o_active      (o_active),
    .o_out_x       (o_out_x),
    .o_peak_mag_sq (o_peak_mag_sq)
);
